// ===== hw/rtl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg
// Types and codes shared by the size-budget LRU cache modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned USED_W  = 24;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned RANK_W  = 6;
    localparam logic [USED_W-1:0] USED_MAX = 24'hFFFFFF;
    localparam logic [USED_W-1:0] BUDGET_RESET = 24'd65536;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_EVICTED  = 3'd3,
        ST_REMOVED  = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FIND,
        B_ACT,
        B_EVICT,
        B_DROP,
        B_PLACE
    } back_state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [KEY_W-1:0]  key_value;
        logic [SIZE_W-1:0] item_size;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  out_key;
        logic [SLOT_W-1:0] entry_count;
        logic [USED_W-1:0] used_total;
        logic              last;
    } out_item_t;

    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slc_front.sv =====
// ----------------------------------------------------------------------------
// slc_front
// Input register: takes a transfer, decodes it into a command, pushes it on.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire slc_pkg::in_item_t in_data,
    output logic                   push,
    output slc_pkg::cmd_t          push_cmd,
    input  wire logic              q_full
);

    logic          f_valid_reg;
    logic          f_valid_next;
    slc_pkg::cmd_t f_cmd_reg;
    logic          accept;

    assign in_stall = f_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = f_valid_reg && !q_full;
    assign push_cmd = f_cmd_reg;

    always_comb
    begin
        f_valid_next = accept || (f_valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_cmd_reg.op   <= slc_pkg::op_t'(in_data.kind);
            f_cmd_reg.key  <= in_data.key_value;
            f_cmd_reg.size <= in_data.item_size;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/slc_queue.sv =====
// ----------------------------------------------------------------------------
// slc_queue
// Two-deep command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire slc_pkg::cmd_t push_cmd,
    output logic               q_full,
    output logic               q_valid,
    input  wire logic          pop,
    output slc_pkg::cmd_t      pop_cmd
);

    slc_pkg::cmd_t ent_reg [2];
    logic          rd_reg;
    logic          rd_next;
    logic          wr_reg;
    logic          wr_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign pop_cmd = ent_reg[rd_reg];

    always_comb
    begin
        rd_next  = pop ? !rd_reg : rd_reg;
        wr_next  = push ? !wr_reg : wr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/slc_back.sv =====
// ----------------------------------------------------------------------------
// slc_back
// Cache table, recency ranks and the sequencer that carries out commands.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_back #(
    parameter int unsigned ENTRIES = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [slc_pkg::USED_W-1:0]  budget,
    input  wire logic                        q_valid,
    output logic                             pop,
    input  wire slc_pkg::cmd_t               pop_cmd,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output slc_pkg::out_item_t               out_data
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned RW = slc_pkg::RANK_W;
    localparam int unsigned UW = slc_pkg::USED_W;
    localparam int unsigned SW = slc_pkg::SIZE_W;

    slc_pkg::back_state_t state_reg;
    slc_pkg::back_state_t state_next;
    slc_pkg::cmd_t        cmd_reg;

    logic [slc_pkg::KEY_W-1:0] key_mem [ENTRIES];
    logic [SW-1:0]             size_mem [ENTRIES];
    logic [RW-1:0]             rank_reg [ENTRIES];
    logic [RW-1:0]             rank_next [ENTRIES];
    logic [ENTRIES-1:0]        valid_reg;
    logic [ENTRIES-1:0]        valid_next;
    logic [UW-1:0]             used_reg;
    logic [UW-1:0]             used_next;
    logic [RW-1:0]             count_reg;
    logic [RW-1:0]             count_next;

    logic                      hit_reg;
    logic [IW-1:0]             hit_slot_reg;
    logic [IW-1:0]             vic_reg;

    logic                      out_valid_reg;
    slc_pkg::out_item_t        out_data_reg;

    logic                      out_free;
    logic                      match_any;
    logic [IW-1:0]             match_slot;
    logic                      vic_any;
    logic [IW-1:0]             vic_slot;
    logic [IW-1:0]             free_slot;
    logic                      stop_evict;
    logic [UW:0]               need;
    logic [UW:0]               sum_add;
    logic                      emit;
    slc_pkg::out_item_t        emit_data;
    logic                      do_drop;
    logic [IW-1:0]             drop_slot;
    logic [RW-1:0]             drop_rank;
    logic [UW-1:0]             drop_size;
    logic                      do_place;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == slc_pkg::B_IDLE) && q_valid;

    // parallel key match, lowest slot wins
    always_comb
    begin
        match_any  = 1'b0;
        match_slot = '0;
        for (int j = ENTRIES - 1; j >= 0; j--)
        begin
            if (valid_reg[j] && key_mem[j] == cmd_reg.key)
            begin
                match_any  = 1'b1;
                match_slot = IW'(j);
            end
        end
    end

    // least recent entry has rank count-1
    always_comb
    begin
        vic_any  = 1'b0;
        vic_slot = '0;
        for (int j = 0; j < ENTRIES; j++)
        begin
            if (valid_reg[j] && rank_reg[j] == count_reg - RW'(1))
            begin
                vic_any  = 1'b1;
                vic_slot = IW'(j);
            end
        end
    end

    always_comb
    begin
        free_slot = '0;
        for (int j = ENTRIES - 1; j >= 0; j--)
        begin
            if (!valid_reg[j])
            begin
                free_slot = IW'(j);
            end
        end
    end

    assign need       = {1'b0, used_reg} + (UW + 1)'(cmd_reg.size);
    assign stop_evict = (count_reg == '0)
                     || ((need <= {1'b0, budget}) && (count_reg < RW'(ENTRIES)));
    assign sum_add    = {1'b0, used_reg} + (UW + 1)'(cmd_reg.size);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slc_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = slc_pkg::B_FIND;
                end
            end
            slc_pkg::B_FIND:
            begin
                state_next = slc_pkg::B_ACT;
            end
            slc_pkg::B_ACT:
            begin
                if (cmd_reg.op == slc_pkg::OP_INSERT)
                begin
                    state_next = slc_pkg::B_EVICT;
                end
                else if (out_free)
                begin
                    state_next = slc_pkg::B_IDLE;
                end
            end
            slc_pkg::B_EVICT:
            begin
                if (stop_evict || !vic_any)
                begin
                    state_next = slc_pkg::B_PLACE;
                end
                else
                begin
                    state_next = slc_pkg::B_DROP;
                end
            end
            slc_pkg::B_DROP:
            begin
                if (out_free)
                begin
                    state_next = slc_pkg::B_EVICT;
                end
            end
            slc_pkg::B_PLACE:
            begin
                if (out_free)
                begin
                    state_next = slc_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = slc_pkg::B_IDLE;
            end
        endcase
    end

    // actions and result
    always_comb
    begin
        emit      = 1'b0;
        emit_data = '0;
        do_drop   = 1'b0;
        drop_slot = hit_slot_reg;
        do_place  = 1'b0;
        valid_next = valid_reg;
        used_next  = used_reg;
        count_next = count_reg;
        for (int j = 0; j < ENTRIES; j++)
        begin
            rank_next[j] = rank_reg[j];
        end

        case (state_reg)
            slc_pkg::B_ACT:
            begin
                case (cmd_reg.op)
                    slc_pkg::OP_LOOKUP:
                    begin
                        if (out_free && hit_reg)
                        begin
                            for (int j = 0; j < ENTRIES; j++)
                            begin
                                if (IW'(j) != hit_slot_reg && valid_reg[j]
                                    && rank_reg[j] < rank_reg[hit_slot_reg])
                                begin
                                    rank_next[j] = rank_reg[j] + RW'(1);
                                end
                            end
                            rank_next[hit_slot_reg] = '0;
                        end
                        emit = out_free;
                    end
                    slc_pkg::OP_REMOVE:
                    begin
                        do_drop = out_free && hit_reg;
                        emit    = out_free;
                    end
                    slc_pkg::OP_INSERT:
                    begin
                        do_drop = hit_reg;
                    end
                    slc_pkg::OP_CLEAR:
                    begin
                        emit = out_free;
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
            slc_pkg::B_DROP:
            begin
                do_drop   = out_free;
                drop_slot = vic_reg;
                emit      = out_free;
            end
            slc_pkg::B_PLACE:
            begin
                do_place = out_free;
                emit     = out_free;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        drop_rank = rank_reg[drop_slot];
        drop_size = UW'(size_mem[drop_slot]);

        if (do_drop)
        begin
            valid_next[drop_slot] = 1'b0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (valid_reg[j] && rank_reg[j] > drop_rank)
                begin
                    rank_next[j] = rank_reg[j] - RW'(1);
                end
            end
            used_next  = (used_reg >= drop_size) ? used_reg - drop_size : '0;
            count_next = count_reg - RW'(1);
        end

        if (do_place)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (valid_reg[j])
                begin
                    rank_next[j] = rank_reg[j] + RW'(1);
                end
            end
            rank_next[free_slot]  = '0;
            valid_next[free_slot] = 1'b1;
            used_next  = sum_add[UW] ? slc_pkg::USED_MAX : sum_add[UW-1:0];
            count_next = count_reg + RW'(1);
        end

        if (state_reg == slc_pkg::B_ACT && cmd_reg.op == slc_pkg::OP_CLEAR && out_free)
        begin
            valid_next = '0;
            used_next  = '0;
            count_next = '0;
        end

        emit_data.entry_count = count_next;
        emit_data.used_total  = used_next;
        emit_data.last        = 1'b1;
        emit_data.out_key     = cmd_reg.key;
        emit_data.slot        = slc_pkg::SLOT_W'(hit_slot_reg);
        case (state_reg)
            slc_pkg::B_DROP:
            begin
                emit_data.status  = slc_pkg::ST_EVICTED;
                emit_data.slot    = slc_pkg::SLOT_W'(vic_reg);
                emit_data.out_key = key_mem[vic_reg];
                emit_data.last    = 1'b0;
            end
            slc_pkg::B_PLACE:
            begin
                emit_data.status = slc_pkg::ST_INSERTED;
                emit_data.slot   = slc_pkg::SLOT_W'(free_slot);
            end
            default:
            begin
                if (cmd_reg.op == slc_pkg::OP_CLEAR)
                begin
                    emit_data.status      = slc_pkg::ST_CLEARED;
                    emit_data.slot        = '0;
                    emit_data.out_key     = '0;
                    emit_data.entry_count = count_reg;
                end
                else if (!hit_reg)
                begin
                    emit_data.status = slc_pkg::ST_MISS;
                    emit_data.slot   = '0;
                end
                else if (cmd_reg.op == slc_pkg::OP_REMOVE)
                begin
                    emit_data.status = slc_pkg::ST_REMOVED;
                end
                else
                begin
                    emit_data.status = slc_pkg::ST_HIT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slc_pkg::B_IDLE;
            valid_reg     <= '0;
            used_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            used_reg  <= used_next;
            count_reg <= count_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            rank_reg[j] <= rank_next[j];
        end
        if (pop)
        begin
            cmd_reg <= pop_cmd;
        end
        if (state_reg == slc_pkg::B_FIND)
        begin
            hit_reg      <= match_any;
            hit_slot_reg <= match_slot;
        end
        if (state_reg == slc_pkg::B_EVICT)
        begin
            vic_reg <= vic_slot;
        end
        if (do_place)
        begin
            key_mem[free_slot]  <= cmd_reg.key;
            size_mem[free_slot] <= cmd_reg.size;
        end
        if (emit)
        begin
            out_data_reg <= emit_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/size_budget_lru_cache.sv =====
// ----------------------------------------------------------------------------
// size_budget_lru_cache
// Keyed LRU cache with a total size budget; evicts least recent entries.
//
//   channel   direction  handshake                 payload
//   in        to block   in_valid / in_stall       in_data  (slc_pkg::in_item_t)
//   out       from block out_valid / out_stall     out_data (slc_pkg::out_item_t)
//   cfg       to block   cfg_we                    cfg_wdata (size budget)
//
// Lookup, remove and clear pass from transfer to result through the input
// register, queue pop, key match and action. An insert adds an eviction pass
// in which the sequencer in the back part steps one victim at a time.
// Reset empties the table at once; no clearing pass.
// A stalled output holds the sequencer; the two-deep queue keeps taking input until full.
// ----------------------------------------------------------------------------
`default_nettype none

module size_budget_lru_cache #(
    parameter int unsigned ENTRIES = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire slc_pkg::in_item_t          in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output slc_pkg::out_item_t              out_data,
    input  wire logic                       cfg_we,
    input  wire logic [slc_pkg::USED_W-1:0] cfg_wdata
);

    logic [slc_pkg::USED_W-1:0] budget_reg;
    logic                       push;
    slc_pkg::cmd_t              push_cmd;
    logic                       q_full;
    logic                       q_valid;
    logic                       pop;
    slc_pkg::cmd_t              pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= slc_pkg::BUDGET_RESET;
        end
        else if (cfg_we)
        begin
            budget_reg <= cfg_wdata;
        end
    end

    slc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    slc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full),
        .q_valid  (q_valid),
        .pop      (pop),
        .pop_cmd  (pop_cmd)
    );

    slc_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .budget    (budget_reg),
        .q_valid   (q_valid),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.entry_count <= slc_pkg::SLOT_W'(ENTRIES)))
        else $error("entry count beyond table size");

    a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == slc_pkg::ST_EVICTED) |-> !out_data.last)
        else $error("eviction marked as final result");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != slc_pkg::ST_EVICTED) |-> out_data.last)
        else $error("final status without last");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == slc_pkg::ST_CLEARED)
            |-> (out_data.used_total == '0))
        else $error("clear left a used total");
`endif

endmodule

`default_nettype wire
